/* src/tsr_pkg.sv */
package tsr_pkg;

    // motion state codes
    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_CLOSING   = 3'd1,
        ST_GRIPPING  = 3'd2,
        ST_RELEASING = 3'd3,
        ST_OPENING   = 3'd4
    } t_motion;

    // request operation codes
    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_GRIP      = 3'd1,
        OP_RELEASE   = 3'd2,
        OP_SET_ANGLE = 3'd3,
        OP_STANDBY   = 3'd4,
        OP_NONE      = 3'd5
    } t_op;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_PITCH_MIN     = 3'd0,
        REG_PITCH_MAX     = 3'd1,
        REG_YAW_MIN       = 3'd2,
        REG_YAW_MAX       = 3'd3,
        REG_PITCH_STANDBY = 3'd4,
        REG_YAW_STANDBY   = 3'd5,
        REG_MOVE_SPEED    = 3'd6
    } t_reg;

    // configuration reset values
    localparam logic signed [14:0] ANGLE_MIN_RST   = -15'sd9600;
    localparam logic signed [14:0] ANGLE_MAX_RST   = 15'sd9600;
    localparam logic signed [14:0] STANDBY_RST     = 15'sd0;
    localparam logic        [15:0] MOVE_SPEED_RST  = 16'd7680;

    // step limit: floor(p/1000) saturated to 16 bits
    // products at or above 65536*1000 saturate, the rest fit in 26 bits
    localparam logic [47:0] STEP_SAT_LIMIT = 48'd65536000;
    localparam logic [26:0] DIV1000_MUL    = 27'd68719477;  // ceil(2^36/1000)

    // half a degree in 1/64 degree units
    localparam logic [17:0] HALF_DEG_UNITS = 18'd32;

    // servo code: (2*clamp(38400 + 4*u, 0, 76725) + 75) / 150
    localparam logic signed [19:0] CODE_NUM_CENTRE = 20'sd38400;
    localparam logic signed [19:0] CODE_NUM_MAX    = 20'sd76725;
    localparam logic        [17:0] CODE_ROUND      = 18'd75;
    localparam logic        [17:0] DIV150_MUL      = 18'd223697; // ceil(2^25/150)

endpackage

/* src/two_axis_servo_ramp_core.sv */
// two-axis slew-rate-limited position ramp
//
// input channel (i_in_valid / o_in_ready) carries one request: an operation
// code, pitch and yaw targets and a millisecond time. output channel
// (o_out_valid / i_out_ready) returns one result per request: the motion
// state, a reached flag and both positions as 10-bit servo codes. the user
// writes settings over the apb port only with no request in flight; unchecked.
//
// the core is a five-register pipeline: input, speed*dt product, step
// limit, position/state update, code conversion into the output register.
// one request is taken every cycle while the output is not stalled; the
// position/state update feeds back on its own state registers.
// the time delta only depends on the previous tick's time, so it is formed
// ahead of the state update.
//
// reset restores the settings to their defaults, returns both axes and
// goals to zero, state to idle and the last tick time to zero.
// when the receiver stalls, the pipeline fills behind the waiting result
// and o_in_ready drops only once every stage holds a request.
module two_axis_servo_ramp_core
    import tsr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_operation,
    input  logic signed [15:0] i_target_pitch,
    input  logic signed [15:0] i_target_yaw,
    input  logic [31:0]        i_tick_ms,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_motion_state,
    output logic               o_reached,
    output logic [9:0]         o_pitch_code,
    output logic [9:0]         o_yaw_code,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // settings
    logic signed [14:0] r_pitch_min, r_pitch_max, r_yaw_min, r_yaw_max;
    logic signed [14:0] r_pitch_standby, r_yaw_standby;
    logic        [15:0] r_move_speed;

    // motion state
    t_motion            r_fsm, n_fsm;
    logic signed [15:0] r_pitch_now, n_pitch_now, r_yaw_now, n_yaw_now;
    logic signed [15:0] r_pitch_goal, n_pitch_goal, r_yaw_goal, n_yaw_goal;
    logic        [31:0] r_last_tick;
    logic               n_reached;

    // pipeline stages
    logic               r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid, r_out_valid;
    logic [2:0]         r_s1_op, r_s2_op, r_s3_op;
    logic signed [15:0] r_s1_tp, r_s2_tp, r_s3_tp;
    logic signed [15:0] r_s1_ty, r_s2_ty, r_s3_ty;
    logic [31:0]        r_s1_dt;
    logic               r_s2_sat, r_s2_dt_nz, r_s3_dt_nz;
    logic [25:0]        r_s2_prod;
    logic [15:0]        r_s3_step;
    t_motion            r_s4_state;
    logic               r_s4_reached;
    logic signed [15:0] r_s4_pitch, r_s4_yaw;
    t_motion            r_out_state;
    logic               r_out_reached;
    logic [9:0]         r_out_pitch, r_out_yaw;

    logic        adv_s1, adv_s2, adv_s3, adv_s4, adv_out, in_acc, cfg_wr;
    logic [47:0] speed_dt;
    logic [52:0] quot_full;
    logic [16:0] pitch_mag, yaw_mag;
    logic        pitch_near, yaw_near;

    // absolute distance between two positions
    function automatic logic [16:0] axis_dist(input logic signed [15:0] a,
                                              input logic signed [15:0] b);
        logic [16:0] d;
        d = {b[15], b} - {a[15], a};
        return d[16] ? (~d + 17'd1) : d;
    endfunction

    // one slew step toward the goal, or onto it
    function automatic logic signed [15:0] advance(input logic signed [15:0] now,
                                                   input logic signed [15:0] goal,
                                                   input logic [16:0] mag,
                                                   input logic [15:0] step);
        logic [16:0] moved;
        if (mag > {1'b0, step}) begin
            if (goal > now) begin
                moved = {now[15], now} + {1'b0, step};
            end else begin
                moved = {now[15], now} - {1'b0, step};
            end
            return moved[15:0];
        end
        return goal;
    endfunction

    // clamp a target into the window, low bound checked first
    function automatic logic signed [15:0] clamp_win(input logic signed [15:0] v,
                                                     input logic signed [14:0] lo,
                                                     input logic signed [14:0] hi);
        logic signed [15:0] lo_x, hi_x;
        lo_x = $signed({lo[14], lo});
        hi_x = $signed({hi[14], hi});
        if (v < lo_x) begin
            return lo_x;
        end
        if (v > hi_x) begin
            return hi_x;
        end
        return v;
    endfunction

    // position to rounded, saturated servo code
    function automatic logic [9:0] to_code(input logic signed [15:0] u);
        logic signed [19:0] num;
        logic signed [19:0] lim;
        logic        [17:0] x;
        logic        [35:0] prod;
        num = CODE_NUM_CENTRE + $signed({{2{u[15]}}, u, 2'b00});
        if (num < 0) begin
            lim = '0;
        end else if (num > CODE_NUM_MAX) begin
            lim = CODE_NUM_MAX;
        end else begin
            lim = num;
        end
        x    = {lim[16:0], 1'b0} + CODE_ROUND;
        prod = 36'(x) * 36'(DIV150_MUL);
        return prod[34:25];
    endfunction

    // apb register port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch_min     <= ANGLE_MIN_RST;
            r_pitch_max     <= ANGLE_MAX_RST;
            r_yaw_min       <= ANGLE_MIN_RST;
            r_yaw_max       <= ANGLE_MAX_RST;
            r_pitch_standby <= STANDBY_RST;
            r_yaw_standby   <= STANDBY_RST;
            r_move_speed    <= MOVE_SPEED_RST;
        end else if (cfg_wr) begin
            unique case (t_reg'(paddr[4:2]))
                REG_PITCH_MIN:     r_pitch_min     <= pwdata[14:0];
                REG_PITCH_MAX:     r_pitch_max     <= pwdata[14:0];
                REG_YAW_MIN:       r_yaw_min       <= pwdata[14:0];
                REG_YAW_MAX:       r_yaw_max       <= pwdata[14:0];
                REG_PITCH_STANDBY: r_pitch_standby <= pwdata[14:0];
                REG_YAW_STANDBY:   r_yaw_standby   <= pwdata[14:0];
                REG_MOVE_SPEED:    r_move_speed    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register read-back
    always_comb begin
        unique case (t_reg'(paddr[4:2]))
            REG_PITCH_MIN:     prdata = {{17{r_pitch_min[14]}}, r_pitch_min};
            REG_PITCH_MAX:     prdata = {{17{r_pitch_max[14]}}, r_pitch_max};
            REG_YAW_MIN:       prdata = {{17{r_yaw_min[14]}}, r_yaw_min};
            REG_YAW_MAX:       prdata = {{17{r_yaw_max[14]}}, r_yaw_max};
            REG_PITCH_STANDBY: prdata = {{17{r_pitch_standby[14]}}, r_pitch_standby};
            REG_YAW_STANDBY:   prdata = {{17{r_yaw_standby[14]}}, r_yaw_standby};
            REG_MOVE_SPEED:    prdata = {16'd0, r_move_speed};
            default:           prdata = '0;
        endcase
    end

    // stage advance chain, a stage moves when it is empty or the next one moves
    assign adv_out    = !r_out_valid || i_out_ready;
    assign adv_s4     = !r_s4_valid || adv_out;
    assign adv_s3     = !r_s3_valid || adv_s4;
    assign adv_s2     = !r_s2_valid || adv_s3;
    assign adv_s1     = !r_s1_valid || adv_s2;
    assign o_in_ready = adv_s1;
    assign in_acc     = i_in_valid && o_in_ready;

    // stage valid flags and last tick time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_last_tick <= '0;
        end else begin
            if (adv_s1) begin
                r_s1_valid <= i_in_valid;
            end
            if (adv_s2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (adv_s3) begin
                r_s3_valid <= r_s2_valid;
            end
            if (adv_s4) begin
                r_s4_valid <= r_s3_valid;
            end
            if (adv_out) begin
                r_out_valid <= r_s4_valid;
            end
            if (in_acc && i_operation == OP_TICK) begin
                r_last_tick <= i_tick_ms;
            end
        end
    end

    // speed times elapsed time, then divide by 1000 with saturation
    assign speed_dt  = 48'(r_move_speed) * 48'(r_s1_dt);
    assign quot_full = 53'(r_s2_prod) * 53'(DIV1000_MUL);

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (adv_s1) begin
            r_s1_op <= i_operation;
            r_s1_tp <= i_target_pitch;
            r_s1_ty <= i_target_yaw;
            r_s1_dt <= i_tick_ms - r_last_tick;
        end
        if (adv_s2) begin
            r_s2_op    <= r_s1_op;
            r_s2_tp    <= r_s1_tp;
            r_s2_ty    <= r_s1_ty;
            r_s2_sat   <= speed_dt >= STEP_SAT_LIMIT;
            r_s2_prod  <= speed_dt[25:0];
            r_s2_dt_nz <= r_s1_dt != '0;
        end
        if (adv_s3) begin
            r_s3_op    <= r_s2_op;
            r_s3_tp    <= r_s2_tp;
            r_s3_ty    <= r_s2_ty;
            r_s3_step  <= r_s2_sat ? 16'hFFFF : quot_full[51:36];
            r_s3_dt_nz <= r_s2_dt_nz;
        end
        if (adv_s4) begin
            r_s4_state   <= n_fsm;
            r_s4_reached <= n_reached;
            r_s4_pitch   <= n_pitch_now;
            r_s4_yaw     <= n_yaw_now;
        end
        if (adv_out) begin
            r_out_state   <= r_s4_state;
            r_out_reached <= r_s4_reached;
            r_out_pitch   <= to_code(r_s4_pitch);
            r_out_yaw     <= to_code(r_s4_yaw);
        end
    end

    // distance to goal and settle test after this step
    assign pitch_mag  = axis_dist(r_pitch_now, r_pitch_goal);
    assign yaw_mag    = axis_dist(r_yaw_now, r_yaw_goal);
    assign pitch_near = {1'b0, pitch_mag} < ({2'b00, r_s3_step} + HALF_DEG_UNITS);
    assign yaw_near   = {1'b0, yaw_mag} < ({2'b00, r_s3_step} + HALF_DEG_UNITS);

    // position and motion state update
    always_comb begin
        n_fsm        = r_fsm;
        n_pitch_now  = r_pitch_now;
        n_yaw_now    = r_yaw_now;
        n_pitch_goal = r_pitch_goal;
        n_yaw_goal   = r_yaw_goal;
        n_reached    = 1'b0;
        case (r_s3_op) inside
            OP_TICK: begin
                if (r_fsm == ST_IDLE || r_fsm == ST_GRIPPING) begin
                    n_reached = 1'b1;
                end else if (r_s3_dt_nz) begin
                    n_pitch_now = advance(r_pitch_now, r_pitch_goal, pitch_mag, r_s3_step);
                    n_yaw_now   = advance(r_yaw_now, r_yaw_goal, yaw_mag, r_s3_step);
                    if (pitch_near && yaw_near) begin
                        n_fsm     = (r_fsm == ST_CLOSING) ? ST_GRIPPING : ST_IDLE;
                        n_reached = 1'b1;
                    end
                end
            end
            OP_GRIP, OP_RELEASE, OP_SET_ANGLE: begin
                n_pitch_goal = clamp_win(r_s3_tp, r_pitch_min, r_pitch_max);
                n_yaw_goal   = clamp_win(r_s3_ty, r_yaw_min, r_yaw_max);
                n_fsm        = (r_s3_op == OP_RELEASE) ? ST_RELEASING : ST_CLOSING;
            end
            OP_STANDBY: begin
                n_pitch_goal = $signed({r_pitch_standby[14], r_pitch_standby});
                n_yaw_goal   = $signed({r_yaw_standby[14], r_yaw_standby});
                n_fsm        = ST_RELEASING;
            end
            default: ;
        endcase
    end

    // state registers, written once per request as it enters the update stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm        <= ST_IDLE;
            r_pitch_now  <= '0;
            r_yaw_now    <= '0;
            r_pitch_goal <= '0;
            r_yaw_goal   <= '0;
        end else if (adv_s4 && r_s3_valid) begin
            r_fsm        <= n_fsm;
            r_pitch_now  <= n_pitch_now;
            r_yaw_now    <= n_yaw_now;
            r_pitch_goal <= n_pitch_goal;
            r_yaw_goal   <= n_yaw_goal;
        end
    end

    // result port
    assign o_out_valid    = r_out_valid;
    assign o_motion_state = r_out_state;
    assign o_reached      = r_out_reached;
    assign o_pitch_code   = r_out_pitch;
    assign o_yaw_code     = r_out_yaw;

    // input stalls only with every stage full behind a stalled result
    a_full_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_s1_valid && r_s2_valid && r_s3_valid && r_s4_valid
                         && r_out_valid && !i_out_ready))
        else $error("input stalled with a free pipeline stage");

    // a taken tick request records its time
    a_last_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_operation == OP_TICK)
        |=> (r_last_tick == $past(i_tick_ms)))
        else $error("last tick time not recorded");

    // the opening state is never entered
    a_no_opening: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fsm != ST_OPENING)
        else $error("motion state entered opening");

    // goals and positions stay within the 15-bit setting range
    a_goal_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pitch_goal[15] == r_pitch_goal[14]) && (r_yaw_goal[15] == r_yaw_goal[14])
        && (r_pitch_now[15] == r_pitch_now[14]) && (r_yaw_now[15] == r_yaw_now[14]))
        else $error("goal or position outside setting range");

endmodule
